[sv/bha_pkg.sv]
// bha_pkg: constants, codes and types shared by the bitmap heap allocator
// no dependencies; imported by bitmap_heap_allocator_core
`timescale 1ns / 1ps

package bha_pkg;

	localparam int HEAP_WORDS    = 4096;
	localparam int TAG_W         = 2;
	localparam int TAGS_PER_WORD = 16;
	localparam int MEM_W         = TAG_W * TAGS_PER_WORD;
	localparam int TAG_WORDS     = (HEAP_WORDS + TAGS_PER_WORD - 1) / TAGS_PER_WORD;
	localparam int IDX_W         = $clog2(HEAP_WORDS);
	localparam int WADDR_W       = $clog2(TAG_WORDS);
	localparam int POS_W         = $clog2(TAGS_PER_WORD);
	localparam int SCAN_LANES    = TAGS_PER_WORD / 2;
	localparam int LANE_W        = $clog2(SCAN_LANES);

	localparam int ADDR_W        = 32;
	localparam int SIZE_W        = 13;
	localparam int CNT_W         = 13;
	localparam int KIND_W        = 2;
	localparam int IN_TDATA_W    = 48;
	localparam int OUT_TDATA_W   = 48;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_QUERY   = 2'd2
	} kind_t;

	typedef enum logic [TAG_W-1:0] {
		TAG_FREE   = 2'd0,
		TAG_END    = 2'd1,
		TAG_START  = 2'd2,
		TAG_SINGLE = 2'd3
	} tag_t;

	typedef enum logic [1:0] {
		RUN_IDLE,
		RUN_COUNT,
		RUN_SKIP
	} run_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_LO,
		ST_A_HI,
		ST_A_R1,
		ST_A_W1,
		ST_A_R2,
		ST_A_W2,
		ST_R_CHK,
		ST_R_SCH,
		ST_DONE
	} fsm_state_t;

endpackage

[sv/bitmap_heap_allocator_core.sv]
// bitmap_heap_allocator_core: first-fit heap allocator over 2-bit word tags
// tags live in a single-port-write, registered-read memory; uses bha_pkg
`timescale 1ns / 1ps

// channel  direction  handshake           payload
// s        in         s_tvalid/s_tready   tuser: kind; tdata: size_words, address
// m        out        m_tvalid/m_tready   tuser: ok; tdata: block_address, free_words
// cfg      in         cfg_wr_en           cfg_wr_data: base_address
//
// allocate: walks the tag memory at 8 tags per cycle, low half then high half of each word;
//   a miss walks every word, a hit stops the walk, then reads and rewrites the start word
//   (single tag for a one-word block, else start tag, then the end word with an end tag)
// release: checks the tag at the address, then searches word by word for the end tag
// query, zero size, address outside the heap or unused kind: no tag memory access
// reset clears all tags at once through per-word valid bits; free count = HEAP_WORDS
// one item at a time; the output register lets the next item in while a result waits

module bitmap_heap_allocator_core
	import bha_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [ADDR_W-1:0]      cfg_wr_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // size_words, address, zero pad
	input  logic [KIND_W-1:0]      s_tuser,   // kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // block_address, free_words, zero pad
	output logic                   m_tuser    // ok
);

	fsm_state_t             state_q, state_d;
	run_mode_t              mode_q, mode_d;
	logic [SIZE_W-1:0]      size_q, size_d;
	logic [WADDR_W-1:0]     widx_q, widx_d;
	logic [CNT_W-1:0]       len_q, len_d;
	logic [IDX_W-1:0]       start_q, start_d;
	logic [IDX_W-1:0]       end_q, end_d;
	logic [IDX_W-1:0]       ix_q, ix_d;
	logic [CNT_W-1:0]       free_q, free_d;
	logic                   res_ok_q, res_ok_d;
	logic [ADDR_W-1:0]      res_addr_q, res_addr_d;
	logic [ADDR_W-1:0]      base_q;
	logic                   out_load;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;

	logic [MEM_W-1:0]       mem [TAG_WORDS];
	logic [TAG_WORDS-1:0]   valid_q;
	logic [MEM_W-1:0]       rd_q;
	logic                   rd_valid_q;
	logic                   rd_en, wr_en;
	logic [WADDR_W-1:0]     rd_addr, wr_addr;
	logic [MEM_W-1:0]       wr_data;
	logic [MEM_W-1:0]       word_c;

	kind_t                  in_kind;
	logic [SIZE_W-1:0]      in_size;
	logic [ADDR_W-1:0]      in_address;
	logic [ADDR_W-1:0]      rel_diff;

	logic                   scan_hi;
	run_mode_t              sc_mode;
	logic [CNT_W-1:0]       sc_len;
	logic [IDX_W-1:0]       sc_start, sc_end;
	logic                   sc_found;

	logic [POS_W-1:0]       search_lo;
	logic                   fnd;
	logic [POS_W-1:0]       fpos;
	logic [CNT_W-1:0]       rel_len;
	logic                   last_word;

	function automatic logic [MEM_W-1:0] put_tag(input logic [MEM_W-1:0] w,
		input logic [POS_W-1:0] pos, input tag_t t);
		logic [MEM_W-1:0] r;
		r = w;
		r[{pos, 1'b0} +: TAG_W] = t;
		return r;
	endfunction

	function automatic tag_t get_tag(input logic [MEM_W-1:0] w, input logic [POS_W-1:0] pos);
		return tag_t'(w[{pos, 1'b0} +: TAG_W]);
	endfunction

	assign in_kind    = kind_t'(s_tuser);
	assign in_size    = s_tdata[SIZE_W-1:0];
	assign in_address = s_tdata[SIZE_W +: ADDR_W];
	assign rel_diff   = in_address - base_q;
	assign word_c     = rd_valid_q ? rd_q : '0;
	assign last_word  = (widx_q == WADDR_W'(TAG_WORDS - 1));

	// tag memory; words never written read as all free
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// first-fit run tracker over one half of a tag word
	always_comb begin : scan_unit
		tag_t             t;
		logic [IDX_W-1:0] idx;
		int               lane_base;
		sc_mode   = mode_q;
		sc_len    = len_q;
		sc_start  = start_q;
		sc_end    = end_q;
		sc_found  = 1'b0;
		lane_base = scan_hi ? SCAN_LANES : 0;
		for (int k = 0; k < SCAN_LANES; k++) begin
			t   = tag_t'(word_c[(lane_base + k) * TAG_W +: TAG_W]);
			idx = {widx_q, scan_hi, LANE_W'(k)};
			if (!sc_found) begin
				if (t == TAG_FREE) begin
					if (sc_mode == RUN_IDLE) begin
						sc_start = idx;
						if (size_q == SIZE_W'(1)) begin
							sc_end   = idx;
							sc_found = 1'b1;
						end else begin
							sc_mode = RUN_COUNT;
							sc_len  = CNT_W'(1);
						end
					end else if (sc_mode == RUN_COUNT) begin
						sc_len = sc_len + CNT_W'(1);
						if (sc_len == size_q) begin
							sc_end   = idx;
							sc_found = 1'b1;
						end
					end
				end else if (t == TAG_START) begin
					sc_mode = RUN_SKIP;
				end else begin
					sc_mode = RUN_IDLE;
				end
			end
		end
	end

	// first end tag at or above search_lo in the current word
	always_comb begin : end_search
		fnd  = 1'b0;
		fpos = '0;
		for (int p = 0; p < TAGS_PER_WORD; p++) begin
			if (!fnd && (POS_W'(p) >= search_lo) && (get_tag(word_c, POS_W'(p)) == TAG_END)) begin
				fnd  = 1'b1;
				fpos = POS_W'(p);
			end
		end
	end

	assign scan_hi   = (state_q == ST_A_HI);
	assign search_lo = (state_q == ST_R_CHK) ? ix_q[POS_W-1:0] : '0;
	assign rel_len   = CNT_W'({widx_q, fpos}) - CNT_W'(ix_q) + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			free_q   <= CNT_W'(HEAP_WORDS);
			res_ok_q <= 1'b0;
			base_q   <= '0;
		end else begin
			state_q  <= state_d;
			free_q   <= free_d;
			res_ok_q <= res_ok_d;
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		size_q     <= size_d;
		widx_q     <= widx_d;
		len_q      <= len_d;
		start_q    <= start_d;
		end_q      <= end_d;
		ix_q       <= ix_d;
		res_addr_q <= res_addr_d;
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		size_d     = size_q;
		widx_d     = widx_q;
		len_d      = len_q;
		start_d    = start_q;
		end_d      = end_q;
		ix_d       = ix_q;
		free_d     = free_q;
		res_ok_d   = res_ok_q;
		res_addr_d = res_addr_q;
		rd_en      = 1'b0;
		rd_addr    = widx_q;
		wr_en      = 1'b0;
		wr_addr    = widx_q;
		wr_data    = word_c;
		out_load   = 1'b0;
		s_tready   = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					res_ok_d   = 1'b0;
					res_addr_d = '0;
					state_d    = ST_DONE;
					case (in_kind)
						KIND_ALLOC: begin
							size_d = in_size;
							if (in_size != '0) begin
								mode_d  = RUN_IDLE;
								len_d   = '0;
								widx_d  = '0;
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = ST_A_LO;
							end
						end
						KIND_RELEASE: begin
							// word index is the byte offset over four, must stay inside the heap
							if (rel_diff[ADDR_W-1:IDX_W+2] == '0) begin
								ix_d    = rel_diff[IDX_W+1:2];
								widx_d  = rel_diff[IDX_W+1:POS_W+2];
								rd_en   = 1'b1;
								rd_addr = rel_diff[IDX_W+1:POS_W+2];
								state_d = ST_R_CHK;
							end
						end
						KIND_QUERY: begin
							res_ok_d = 1'b1;
						end
						default: begin
							res_ok_d = 1'b0;
						end
					endcase
				end
			end
			ST_A_LO, ST_A_HI: begin
				mode_d  = sc_mode;
				len_d   = sc_len;
				start_d = sc_start;
				end_d   = sc_end;
				if (sc_found) begin
					state_d = ST_A_R1;
				end else if (state_q == ST_A_LO) begin
					state_d = ST_A_HI;
				end else if (last_word) begin
					state_d = ST_DONE;
				end else begin
					widx_d  = widx_q + WADDR_W'(1);
					rd_en   = 1'b1;
					rd_addr = widx_q + WADDR_W'(1);
					state_d = ST_A_LO;
				end
			end
			ST_A_R1: begin
				rd_en   = 1'b1;
				rd_addr = start_q[IDX_W-1:POS_W];
				state_d = ST_A_W1;
			end
			ST_A_W1: begin
				wr_en   = 1'b1;
				wr_addr = start_q[IDX_W-1:POS_W];
				if (start_q == end_q) begin
					wr_data    = put_tag(word_c, start_q[POS_W-1:0], TAG_SINGLE);
					free_d     = free_q - size_q;
					res_ok_d   = 1'b1;
					res_addr_d = base_q + ADDR_W'({start_q, 2'b00});
					state_d    = ST_DONE;
				end else begin
					wr_data = put_tag(word_c, start_q[POS_W-1:0], TAG_START);
					state_d = ST_A_R2;
				end
			end
			ST_A_R2: begin
				rd_en   = 1'b1;
				rd_addr = end_q[IDX_W-1:POS_W];
				state_d = ST_A_W2;
			end
			ST_A_W2: begin
				wr_en      = 1'b1;
				wr_addr    = end_q[IDX_W-1:POS_W];
				wr_data    = put_tag(word_c, end_q[POS_W-1:0], TAG_END);
				free_d     = free_q - size_q;
				res_ok_d   = 1'b1;
				res_addr_d = base_q + ADDR_W'({start_q, 2'b00});
				state_d    = ST_DONE;
			end
			ST_R_CHK: begin
				state_d = ST_DONE;
				case (get_tag(word_c, ix_q[POS_W-1:0]))
					TAG_SINGLE: begin
						wr_en    = 1'b1;
						wr_data  = put_tag(word_c, ix_q[POS_W-1:0], TAG_FREE);
						free_d   = free_q + CNT_W'(1);
						res_ok_d = 1'b1;
					end
					TAG_START: begin
						wr_en   = 1'b1;
						wr_data = put_tag(word_c, ix_q[POS_W-1:0], TAG_FREE);
						if (fnd) begin
							wr_data  = put_tag(put_tag(word_c, ix_q[POS_W-1:0], TAG_FREE),
								fpos, TAG_FREE);
							free_d   = free_q + rel_len;
							res_ok_d = 1'b1;
						end else if (!last_word) begin
							widx_d  = widx_q + WADDR_W'(1);
							rd_en   = 1'b1;
							rd_addr = widx_q + WADDR_W'(1);
							state_d = ST_R_SCH;
						end
					end
					default: begin
						res_ok_d = 1'b0;
					end
				endcase
			end
			ST_R_SCH: begin
				if (fnd) begin
					wr_en    = 1'b1;
					wr_data  = put_tag(word_c, fpos, TAG_FREE);
					free_d   = free_q + rel_len;
					res_ok_d = 1'b1;
					state_d  = ST_DONE;
				end else if (last_word) begin
					// start tag without end tag: start stays cleared, count untouched
					state_d = ST_DONE;
				end else begin
					widx_d  = widx_q + WADDR_W'(1);
					rd_en   = 1'b1;
					rd_addr = widx_q + WADDR_W'(1);
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {(OUT_TDATA_W - ADDR_W - CNT_W)'(0), free_q, res_addr_q};
			m_tuser_q <= res_ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(HEAP_WORDS))
		else $error("free word count above heap size");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_A_W1 || state_q == ST_A_W2 ||
			state_q == ST_R_CHK || state_q == ST_R_SCH))
		else $error("tag memory written outside an update step");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new transaction taken while one is in progress");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !out_load)
		else $error("result overwritten before it was taken");

endmodule

[tb/sv/bitmap_heap_allocator_core_tb.sv]
// bitmap_heap_allocator_core_tb: self-checking bench for the first-fit heap allocator
// depends on bha_pkg and bitmap_heap_allocator_core; tracks tags and free count in a class
`timescale 1ns / 1ps

module bitmap_heap_allocator_core_tb
	import bha_pkg::*;
;

	typedef struct {
		logic              ok;
		logic [ADDR_W-1:0] blk_addr;
		logic [CNT_W-1:0]  free_cnt;
	} heap_resp_t;

	class heap_scoreboard;
		tag_t              tags [HEAP_WORDS];
		int unsigned       free_count;
		logic [ADDR_W-1:0] base;
		heap_resp_t        pending_resps [$];
		int unsigned       errors;
		int unsigned       checked;

		function new();
			foreach (tags[i]) tags[i] = TAG_FREE;
			free_count = HEAP_WORDS;
			base       = '0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void set_base(logic [ADDR_W-1:0] value);
			base = value;
		endfunction

		// first fit: a start tag skips until its end tag, any other tag restarts the run
		function bit first_fit(int unsigned n, output int unsigned start);
			run_mode_t   mode;
			int unsigned len;
			bit          found;
			mode  = RUN_IDLE;
			len   = 0;
			found = 0;
			start = 0;
			for (int i = 0; i < HEAP_WORDS && !found; i++) begin
				if (tags[i] == TAG_FREE) begin
					if (mode == RUN_IDLE) begin
						start = i;
						len   = 1;
						if (n == 1)
							found = 1;
						else
							mode = RUN_COUNT;
					end else if (mode == RUN_COUNT) begin
						len++;
						if (len == n)
							found = 1;
					end
				end else if (tags[i] == TAG_START) begin
					mode = RUN_SKIP;
				end else begin
					mode = RUN_IDLE;
				end
			end
			return found;
		endfunction

		function bit release_block(logic [ADDR_W-1:0] addr);
			logic [ADDR_W-1:0] offs;
			int unsigned       ix;
			offs = addr - base;
			ix   = offs >> 2;
			if (ix >= HEAP_WORDS)
				return 0;
			if (tags[ix] == TAG_SINGLE) begin
				tags[ix] = TAG_FREE;
				free_count++;
				return 1;
			end
			if (tags[ix] != TAG_START)
				return 0;
			tags[ix] = TAG_FREE;
			for (int i = ix; i < HEAP_WORDS; i++) begin
				if (tags[i] == TAG_END) begin
					tags[i] = TAG_FREE;
					free_count += i - ix + 1;
					return 1;
				end
			end
			// start without end: counter left alone
			return 0;
		endfunction

		// called for each accepted request transaction; returns the expected response
		function heap_resp_t note_request(logic [KIND_W-1:0] kind, int unsigned size,
			logic [ADDR_W-1:0] addr);
			heap_resp_t  r;
			int unsigned start;
			r.ok       = 0;
			r.blk_addr = '0;
			if (kind == KIND_ALLOC) begin
				if (size != 0 && first_fit(size, start)) begin
					if (size == 1) begin
						tags[start] = TAG_SINGLE;
					end else begin
						tags[start]            = TAG_START;
						tags[start + size - 1] = TAG_END;
					end
					free_count -= size;
					r.ok       = 1;
					r.blk_addr = base + (start << 2);
				end
			end else if (kind == KIND_RELEASE) begin
				r.ok = release_block(addr);
			end else if (kind == KIND_QUERY) begin
				r.ok = 1;
			end
			r.free_cnt = free_count[CNT_W-1:0];
			pending_resps.push_back(r);
			return r;
		endfunction

		function void check_response(logic ok, logic [ADDR_W-1:0] blk_addr,
			logic [CNT_W-1:0] free_cnt);
			heap_resp_t e;
			checked++;
			if (pending_resps.size() == 0) begin
				$error("response with nothing outstanding: ok=%0d addr=%h free=%0d",
					ok, blk_addr, free_cnt);
				errors++;
				return;
			end
			e = pending_resps.pop_front();
			if (ok !== e.ok) begin
				$error("ok: expected %0d, got %0d", e.ok, ok);
				errors++;
			end
			if (blk_addr !== e.blk_addr) begin
				$error("block_address: expected %h, got %h", e.blk_addr, blk_addr);
				errors++;
			end
			if (free_cnt !== e.free_cnt) begin
				$error("free_words: expected %0d, got %0d", e.free_cnt, free_cnt);
				errors++;
			end
		endfunction
	endclass

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		int unsigned idx;
		int unsigned len;
	} live_blk_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [ADDR_W-1:0]      cfg_wr_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	heap_scoreboard sb;
	live_blk_t      live_blks [$];
	int unsigned    burst_left;
	int unsigned    cnt_alloc, cnt_alloc_ok, cnt_rel, cnt_rel_ok, cnt_query, cnt_unused;
	int unsigned    cnt_bases;

	bitmap_heap_allocator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// give up well past the slowest legal run
	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// response side: stall behavior switches between a few patterns
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned stall_left;
		m_tready   = 0;
		mode       = 0;
		mode_left  = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 400);
			end
			mode_left--;
			case (mode)
				0: m_tready = 1;
				1: m_tready = 1'($urandom_range(0, 1));
				2: begin
					if (stall_left == 0 && $urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 8);
					m_tready = (stall_left == 0);
					if (stall_left != 0)
						stall_left--;
				end
				default: m_tready = ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_response(m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: CNT_W]);
	end

	function automatic void forget_block(int unsigned ix);
		foreach (live_blks[i]) begin
			if (live_blks[i].idx == ix) begin
				live_blks.delete(i);
				return;
			end
		end
	endfunction

	task automatic send_request(logic [KIND_W-1:0] kind, int unsigned size,
		logic [ADDR_W-1:0] addr);
		heap_resp_t  r;
		int unsigned gap;
		live_blk_t   b;
		logic [ADDR_W-1:0] offs;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				s_tvalid = 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 20);
		end
		s_tvalid = 1;
		s_tuser  = kind;
		s_tdata  = {3'b000, addr, SIZE_W'(size)};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		r = sb.note_request(kind, size, addr);
		case (kind)
			KIND_ALLOC: begin
				cnt_alloc++;
				if (r.ok) begin
					cnt_alloc_ok++;
					offs  = r.blk_addr - sb.base;
					b.idx = offs >> 2;
					b.len = size;
					live_blks.push_back(b);
				end
			end
			KIND_RELEASE: begin
				cnt_rel++;
				if (r.ok) begin
					cnt_rel_ok++;
					offs = addr - sb.base;
					forget_block(offs >> 2);
				end
			end
			KIND_QUERY: cnt_query++;
			default:    cnt_unused++;
		endcase
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (sb.pending_resps.size() != 0)
			@(posedge clk);
		// every request has a response, so the core is idle here
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   = 1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 0;
		sb.set_base(value);
		cnt_bases++;
	endtask

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)  return 0;
		if (r < 70) return $urandom_range(1, 16);
		if (r < 92) return $urandom_range(17, 256);
		if (r < 98) return $urandom_range(257, 1024);
		return $urandom_range(1025, HEAP_WORDS);
	endfunction

	task automatic run_random(int unsigned count);
		int unsigned       r;
		int unsigned       rel_pct;
		live_blk_t         b;
		logic [ADDR_W-1:0] a;
		repeat (count) begin
			r       = $urandom_range(0, 99);
			rel_pct = (live_blks.size() == 0) ? 0 : (sb.free_count < 800 ? 60 : 32);
			if (r < rel_pct) begin
				// well-formed release of a live block, low address bits random
				b = live_blks[$urandom_range(0, live_blks.size() - 1)];
				a = sb.base + (b.idx << 2) + $urandom_range(0, 3);
				send_request(KIND_RELEASE, $urandom_range(0, 8191), a);
			end else if (r < 88) begin
				send_request(KIND_ALLOC, pick_size(), $urandom());
			end else if (r < 94) begin
				// bad releases: anywhere, in or just past the heap, or on an end tag
				case ($urandom_range(0, 2))
					0: a = $urandom();
					1: a = sb.base + ($urandom_range(0, HEAP_WORDS + 15) << 2)
						+ $urandom_range(0, 3);
					default: begin
						if (live_blks.size() != 0) begin
							b = live_blks[$urandom_range(0, live_blks.size() - 1)];
							a = sb.base + ((b.idx + b.len - 1) << 2);
						end else begin
							a = $urandom();
						end
					end
				endcase
				send_request(KIND_RELEASE, $urandom_range(0, 8191), a);
			end else if (r < 97) begin
				send_request(KIND_QUERY, $urandom_range(0, 8191), $urandom());
			end else begin
				send_request(KIND_UNUSED, $urandom_range(0, 8191), $urandom());
			end
		end
		drain();
	endtask

	initial begin
		logic [ADDR_W-1:0] bases [6];
		sb           = new();
		burst_left   = 0;
		cnt_alloc    = 0;
		cnt_alloc_ok = 0;
		cnt_rel      = 0;
		cnt_rel_ok   = 0;
		cnt_query    = 0;
		cnt_unused   = 0;
		cnt_bases    = 0;
		arst_n       = 0;
		cfg_wr_en    = 0;
		cfg_wr_data  = '0;
		s_tvalid     = 0;
		s_tdata      = '0;
		s_tuser      = KIND_QUERY;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, every kind, each failure path, base left at reset value
		send_request(KIND_QUERY, 0, 0);
		send_request(KIND_ALLOC, 0, 0);
		send_request(KIND_UNUSED, 13'h1FFF, 32'hFFFF_FFFF);
		send_request(KIND_ALLOC, HEAP_WORDS, 0);
		send_request(KIND_ALLOC, 1, 0);
		send_request(KIND_QUERY, 13'h1FFF, 32'hFFFF_FFFF);
		send_request(KIND_RELEASE, 0, 4 * (HEAP_WORDS - 1));
		send_request(KIND_RELEASE, 0, 32'h3);
		send_request(KIND_ALLOC, 1, 0);
		send_request(KIND_ALLOC, 5, 0);
		send_request(KIND_ALLOC, 1, 0);
		send_request(KIND_RELEASE, 0, 4 * 3);
		send_request(KIND_RELEASE, 0, 4 * HEAP_WORDS);
		send_request(KIND_RELEASE, 0, 32'hFFFF_FFFF);
		send_request(KIND_RELEASE, 0, 4);
		send_request(KIND_ALLOC, 3, 0);
		send_request(KIND_ALLOC, 2, 0);
		send_request(KIND_RELEASE, 0, 0);
		send_request(KIND_RELEASE, 0, 4 * 6 + 2);
		send_request(KIND_ALLOC, HEAP_WORDS - 6, 0);
		send_request(KIND_ALLOC, 2, 0);
		send_request(KIND_ALLOC, 1, 0);
		send_request(KIND_ALLOC, 1, 0);
		drain();

		bases[0] = 32'hFFFF_FFFC;
		bases[1] = 32'hFFFF_FFFF;
		bases[2] = $urandom();
		bases[3] = 32'h0000_1000;
		bases[4] = $urandom() & ~32'h3;
		bases[5] = 32'h0000_0000;
		foreach (bases[p]) begin
			write_base(bases[p]);
			run_random(300);
		end

		repeat (20) @(posedge clk);
		$display("covered %0d requests: %0d allocs (%0d granted), %0d releases (%0d freed),",
			cnt_alloc + cnt_rel + cnt_query + cnt_unused, cnt_alloc, cnt_alloc_ok,
			cnt_rel, cnt_rel_ok);
		$display("  %0d queries, %0d unused-kind, %0d base settings, %0d responses checked",
			cnt_query, cnt_unused, cnt_bases, sb.checked);
		if (sb.errors == 0 && sb.pending_resps.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
